// ===== rtl/sbti_pkg.sv =====
// Shared constants, codes and types for the stack with top range increment.
`timescale 1ns / 1ps

package sbti_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int DATA_W      = 32;
  localparam int COUNT_W     = 5;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
  localparam int CMP_W       = (LEVEL_W > COUNT_W) ? LEVEL_W : COUNT_W;

  localparam int IN_DATA_W   = ((DATA_W + COUNT_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((DATA_W + LEVEL_W + 1 + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_ADD  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Command broadcast to every cell for one accepted beat.
  typedef struct packed {
    logic               push;
    logic               pop;
    logic               add;
    logic [LEVEL_W-1:0] k;
    logic [DATA_W-1:0]  amount;
  } cell_ctrl_t;

endpackage

// ===== rtl/sbti_cell.sv =====
// One stack cell: holds one word, shifts with its neighbors, adds in place.
`timescale 1ns / 1ps

module sbti_cell (
  input  logic                        clk,
  input  sbti_pkg::cell_ctrl_t        ctrl,
  input  logic [sbti_pkg::LEVEL_W-1:0] pos,
  input  logic [sbti_pkg::DATA_W-1:0]  from_above,
  input  logic [sbti_pkg::DATA_W-1:0]  from_below,
  output logic [sbti_pkg::DATA_W-1:0]  q,
  output logic [sbti_pkg::DATA_W-1:0]  q_next
);
  import sbti_pkg::*;

  logic add_hit;

  // Cell positions count down from the top; the top k cells take the add.
  assign add_hit = ctrl.add && (pos < ctrl.k);

  always_comb begin
    priority if (ctrl.push) begin
      q_next = from_above;
    end else if (ctrl.pop) begin
      q_next = from_below;
    end else if (add_hit) begin
      q_next = q + ctrl.amount;
    end else begin
      q_next = q;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

// ===== rtl/stack_with_top_range_increment_top.sv =====
// Top level of the bounded stack with add-to-top-k, built as a chain of cells.
`timescale 1ns / 1ps
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tuser: op; tdata: value, count
//  m_      | out | m_tvalid/m_tready  | tuser: status; tdata: top_value, fill_level,
//          |     |                    |        empty_res
//
//  The cells update and the result is registered on the edge that accepts
//  the beat. The pace is set by the single output register: a new beat is
//  taken when that register is empty or drained in the same cycle, so one
//  beat per cycle flows while m_tready stays high.
//  rst clears the fill level and the output valid; cell contents stay
//  undefined and are never shown because the fill level gates them.

module stack_with_top_range_increment_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [1:0] op
  input  logic [sbti_pkg::OP_W-1:0]       s_tuser,
  // [31:0] value, [36:32] count, [39:37] zero
  input  logic [sbti_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [1:0] status
  output logic [sbti_pkg::STATUS_W-1:0]   m_tuser,
  // [31:0] top_value, [36:32] fill_level, [37] empty_res, [39:38] zero
  output logic [sbti_pkg::OUT_DATA_W-1:0] m_tdata
);
  import sbti_pkg::*;

  localparam int PAD_W = OUT_DATA_W - DATA_W - LEVEL_W - 1;

  logic [LEVEL_W-1:0]  level;
  logic [LEVEL_W-1:0]  level_next;
  logic                accept;
  logic [OP_W-1:0]     op;
  logic [DATA_W-1:0]   value;
  logic [COUNT_W-1:0]  count;
  logic                full;
  logic                empty;
  logic [CMP_W-1:0]    count_ext;
  logic [CMP_W-1:0]    level_ext;
  logic [LEVEL_W-1:0]  k;
  logic [STATUS_W-1:0] status_next;
  cell_ctrl_t          ctrl;

  logic [DATA_W-1:0] cell_q    [STACK_DEPTH];
  logic [DATA_W-1:0] cell_next [STACK_DEPTH];

  // Take a beat when the result register is free or drains this cycle.
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign op    = s_tuser;
  assign value = s_tdata[DATA_W-1:0];
  assign count = s_tdata[DATA_W +: COUNT_W];

  assign full  = (level == LEVEL_W'(STACK_DEPTH));
  assign empty = (level == '0);

  // Clamp the increment span to the fill level.
  assign count_ext = CMP_W'(count);
  assign level_ext = CMP_W'(level);
  assign k = (count_ext > level_ext) ? level : LEVEL_W'(count_ext);

  // Build the cell command; rejected pushes and pops leave every cell alone.
  always_comb begin
    ctrl.push   = accept && (op == OP_PUSH) && !full;
    ctrl.pop    = accept && (op == OP_POP) && !empty;
    ctrl.add    = accept && (op == OP_ADD);
    ctrl.k      = k;
    ctrl.amount = value;
  end

  always_comb begin
    level_next  = level;
    status_next = ST_OK;
    unique case (op)
      OP_PUSH: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          level_next = level + LEVEL_W'(1);
        end
      end
      OP_POP: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          level_next = level - LEVEL_W'(1);
        end
      end
      default: begin
        // Add and the unused code keep the level.
        level_next = level;
      end
    endcase
  end

  // Cell 0 is the top of the stack; a push shifts words down the chain,
  // a pop shifts them up.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] above;
    logic [DATA_W-1:0] below;

    if (i == 0) begin : g_first
      assign above = value;
    end else begin : g_mid_a
      assign above = cell_q[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_last
      assign below = cell_q[i];
    end else begin : g_mid_b
      assign below = cell_q[i+1];
    end

    sbti_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .pos        (LEVEL_W'(i)),
      .from_above (above),
      .from_below (below),
      .q          (cell_q[i]),
      .q_next     (cell_next[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else if (accept) begin
      level <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Register the result beat from the post-operation state.
  always_ff @(posedge clk) begin
    if (accept) begin
      m_tuser <= status_next;
      m_tdata <= {{PAD_W{1'b0}},
                  (level_next == '0),
                  level_next,
                  (level_next == '0) ? {DATA_W{1'b0}} : cell_next[0]};
    end
  end

endmodule

// ===== verif/stack_with_top_range_increment_top_test.sv =====
// Self-checking testbench for the bounded stack with add-to-top-k over stream handshakes.
`timescale 1ns / 1ps

module stack_with_top_range_increment_top_test;
  import sbti_pkg::*;

  // The op field has one code the block does not use; it must act as a no-op.
  localparam logic [OP_W-1:0] OP_NOP = 2'd3;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [DATA_W-1:0]   top;
    logic [LEVEL_W-1:0]  level;
    logic                empty;
    logic [STATUS_W-1:0] status;
  } stack_reply_t;

  typedef enum {MODE_FILL, MODE_DRAIN, MODE_CHURN} traffic_mode_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [OP_W-1:0]       s_tuser;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [STATUS_W-1:0]   m_tuser;
  logic [OUT_DATA_W-1:0] m_tdata;

  // Shadow copy of the stack, advanced once per accepted input beat.
  logic [DATA_W-1:0] stack_words [STACK_DEPTH];
  int                stack_fill;

  // Replies the block owes us, oldest first.
  stack_reply_t reply_queue [$];

  int send_idle_pct;
  int recv_idle_pct;
  int fail_count;
  int cycle_count;
  int beats_sent;
  int replies_checked;
  int refused_pushes;
  int refused_pops;

  stack_with_top_range_increment_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Bound the run: a hung handshake must not stall the simulation.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d replies outstanding",
               cycle_count, reply_queue.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Apply one operation to the shadow stack and return what the block should report.
  function automatic stack_reply_t apply_stack_op(input logic [OP_W-1:0] op,
                                                  input logic [DATA_W-1:0] value,
                                                  input logic [COUNT_W-1:0] count);
    stack_reply_t reply;
    int           span;
    int           idx;
    reply.status = ST_OK;
    case (op)
      OP_PUSH: begin
        if (stack_fill >= STACK_DEPTH) begin
          reply.status = ST_FULL;
        end else begin
          stack_words[stack_fill] = value;
          stack_fill++;
        end
      end
      OP_POP: begin
        if (stack_fill == 0) begin
          reply.status = ST_EMPTY;
        end else begin
          stack_fill--;
        end
      end
      OP_ADD: begin
        // Clamp the span to the fill level; the add wraps modulo 2^32.
        span = int'(count);
        if (span > stack_fill) span = stack_fill;
        for (idx = stack_fill - span; idx < stack_fill; idx++) begin
          stack_words[idx] = stack_words[idx] + value;
        end
      end
      default: begin
      end
    endcase
    reply.top   = (stack_fill > 0) ? stack_words[stack_fill - 1] : '0;
    reply.level = LEVEL_W'(stack_fill);
    reply.empty = (stack_fill == 0);
    return reply;
  endfunction

  // Words biased toward the sign and carry boundaries.
  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(15))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      4:       return 32'h0000_0001;
      5:       return DATA_W'($urandom_range(255));
      default: return $urandom;
    endcase
  endfunction

  task automatic report_fail(input string what, input stack_reply_t want,
                             input stack_reply_t got);
    if (fail_count < REPORT_MAX) begin
      $display("%0t %s: expected top=%h level=%0d empty=%b status=%0d",
               $realtime, what, want.top, want.level, want.empty, want.status);
      $display("    got top=%h level=%0d empty=%b status=%0d",
               got.top, got.level, got.empty, got.status);
    end
    fail_count++;
  endtask

  // Offer one beat, with random gaps ahead of it, and book its reply on acceptance.
  task automatic send_beat(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value,
                           input logic [COUNT_W-1:0] count);
    logic [IN_DATA_W-1:0] payload;
    stack_reply_t         reply;
    payload = '0;
    payload[DATA_W-1:0]       = value;
    payload[DATA_W +: COUNT_W] = count;
    @(negedge clk);
    // Drop valid for the gap; raise it again only on a later falling edge.
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= payload;
    // Hold the beat until the block takes it.
    do @(posedge clk); while (!s_tready);
    reply = apply_stack_op(op, value, count);
    if (reply.status == ST_FULL)  refused_pushes++;
    if (reply.status == ST_EMPTY) refused_pops++;
    reply_queue.insert(reply_queue.size(), reply);
    beats_sent++;
  endtask

  // Receiver: stall at random at the configured rate.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each accepted reply beat with the oldest outstanding prediction.
  always @(posedge clk) begin : check_replies
    stack_reply_t want;
    stack_reply_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.top    = m_tdata[DATA_W-1:0];
      got.level  = m_tdata[DATA_W +: LEVEL_W];
      got.empty  = m_tdata[DATA_W + LEVEL_W];
      got.status = m_tuser;
      if (reply_queue.size() == 0) begin
        want = '0;
        report_fail("Unexpected reply", want, got);
      end else begin
        want = reply_queue.pop_front();
        if (got !== want) report_fail("Reply mismatch", want, got);
        replies_checked++;
      end
    end
  end

  // Pop, add and no-op on an empty stack must leave it empty.
  task automatic test_empty_stack();
    send_beat(OP_POP, 32'h1234_5678, 5'd0);
    send_beat(OP_ADD, 32'h0000_0007, 5'd5);
    send_beat(OP_NOP, 32'hFFFF_FFFF, 5'd31);
  endtask

  // Fill to the depth with boundary words, then push once more onto the full stack.
  task automatic test_fill_and_overflow();
    int n;
    for (n = 0; n < STACK_DEPTH; n++) begin
      case (n % 4)
        0:       send_beat(OP_PUSH, 32'h7FFF_FFFF, 5'd0);
        1:       send_beat(OP_PUSH, 32'h8000_0000, 5'd31);
        2:       send_beat(OP_PUSH, 32'hFFFF_FFFF, 5'd16);
        default: send_beat(OP_PUSH, $urandom, 5'($urandom_range(31)));
      endcase
    end
    send_beat(OP_PUSH, 32'hDEAD_BEEF, 5'd0);
  endtask

  // Zero count, partial span, clamped spans and wrapping adds on a full stack, then a no-op and a pop.
  task automatic test_increment_range();
    send_beat(OP_ADD, 32'h0000_0005, 5'd0);
    send_beat(OP_ADD, 32'h0000_0001, 5'd3);
    send_beat(OP_ADD, 32'h7FFF_FFFF, 5'd31);
    send_beat(OP_ADD, 32'h8000_0000, 5'd17);
    send_beat(OP_ADD, 32'hFFFF_FFFF, 5'd16);
    send_beat(OP_NOP, 32'h5555_5555, 5'd21);
    send_beat(OP_POP, 32'hAAAA_AAAA, 5'd10);
  endtask

  // Runs of fill, drain and churn traffic so both bounds are hit again and again.
  task automatic test_random_traffic(input int n_items, input int tx_idle, input int rx_idle);
    traffic_mode_t   mode;
    int              run_left;
    int              pick;
    int              n;
    logic [OP_W-1:0] op;
    logic [COUNT_W-1:0] count;
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    run_left = 0;
    mode = MODE_CHURN;
    for (n = 0; n < n_items; n++) begin
      if (run_left == 0) begin
        mode     = traffic_mode_t'($urandom_range(2));
        run_left = $urandom_range(10, 50);
      end
      run_left--;
      pick = $urandom_range(99);
      if (pick < 3) begin
        op = OP_NOP;
      end else begin
        case (mode)
          MODE_FILL:  op = (pick < 65) ? OP_PUSH : ((pick < 80) ? OP_POP : OP_ADD);
          MODE_DRAIN: op = (pick < 20) ? OP_PUSH : ((pick < 75) ? OP_POP : OP_ADD);
          default:    op = (pick < 35) ? OP_PUSH : ((pick < 65) ? OP_POP : OP_ADD);
        endcase
      end
      // Mostly spans near the fill level, some over the whole range, a few past the depth.
      pick = $urandom_range(9);
      if (pick < 7) begin
        count = COUNT_W'($urandom_range((stack_fill < STACK_DEPTH) ? stack_fill + 1 : STACK_DEPTH));
      end else if (pick < 9) begin
        count = COUNT_W'($urandom_range(STACK_DEPTH));
      end else begin
        count = COUNT_W'($urandom_range(STACK_DEPTH + 1, 31));
      end
      send_beat(op, pick_word(), count);
    end
  endtask

  initial begin
    int settle;
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tuser       = '0;
    s_tdata       = '0;
    m_tready      = 1'b0;
    stack_fill    = 0;
    cycle_count   = 0;
    fail_count    = 0;
    beats_sent    = 0;
    replies_checked = 0;
    refused_pushes  = 0;
    refused_pops    = 0;
    send_idle_pct = 36;
    recv_idle_pct = 73;
    foreach (stack_words[i]) stack_words[i] = '0;

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    test_empty_stack();
    test_fill_and_overflow();
    test_increment_range();
    test_random_traffic(420, 36, 73);
    test_random_traffic(420, 73, 36);
    test_random_traffic(410, 0, 0);

    @(negedge clk);
    s_tvalid <= 1'b0;
    recv_idle_pct = 0;

    // Wait out the outstanding replies, then keep watching for any stray beat.
    while (reply_queue.size() != 0) @(posedge clk);
    for (settle = 0; settle < DRAIN_CYCLES; settle++) @(posedge clk);

    $display("Sent %0d beats and checked %0d replies across three idle patterns",
             beats_sent, replies_checked);
    $display("Bounds hit: %0d pushes refused when full, %0d pops refused when empty",
             refused_pushes, refused_pops);
    if (fail_count == 0 && reply_queue.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sbti_pkg.sv
rtl/sbti_cell.sv
rtl/stack_with_top_range_increment_top.sv
verif/stack_with_top_range_increment_top_test.sv
